[rtl/cst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants of the command slot tracker
// Field widths, word layouts, operation and status codes, register indexes
// and the control and status bundles between the top level and the scanner.
// ----------------------------------------------------------------------------
package cst_pkg;

    // Input word layout, lowest bit first.
    localparam int RUNNING_W   = 32;
    localparam int COUNT_W     = 8;
    localparam int STATUS_IN_W = 32;
    localparam int S_DATA_W    = 80;

    // Output word layout.
    localparam int STATUS_W    = 3;
    localparam int SLOT_W      = 5;
    localparam int M_DATA_W    = 16;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int ENTRIES_W   = 5;

    localparam logic [CFG_INDEX_W-1:0] CFG_PORT_PRESENT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ENTRIES  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ERROR_MASK   = 2'd2;

    localparam logic [ENTRIES_W-1:0]  MAX_ENTRIES_RESET = 5'd8;
    localparam logic [CFG_DATA_W-1:0] ERROR_MASK_RESET  = 32'h7800_0000;

    // Sectors covered by one descriptor entry, minus one, for rounding up.
    localparam logic [COUNT_W:0] ENTRY_ROUND = 9'd15;

    // Operation on the input side.
    localparam logic OP_SUBMIT    = 1'b0;
    localparam logic OP_INTERRUPT = 1'b1;

    // Kind of a result word.
    localparam logic KIND_SUBMIT     = 1'b0;
    localparam logic KIND_COMPLETION = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_ACCEPTED   = 3'd0,
        STAT_ZERO_COUNT = 3'd1,
        STAT_NO_PORT    = 3'd2,
        STAT_TOO_MANY   = 3'd3,
        STAT_NO_SLOT    = 3'd4
    } status_t;

    // Control from the sequencer to the slot scanner.
    typedef struct packed {
        logic load;
        logic step;
    } scan_ctrl_t;

    // Status from the slot scanner.
    typedef struct packed {
        logic hit;
        logic last;
    } scan_stat_t;

endpackage

[rtl/command_slot_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_slot_tracker: command slot bookkeeping for one storage port
// Checks submit requests, allocates the lowest free slot, and on interrupt
// events releases finished slots and reports them one word at a time.
//
//   Channel   Handshake            Payload
//   s_        s_tvalid / s_tready  s_tuser op, s_tdata request or event
//   m_        m_tvalid / m_tready  m_tuser kind, m_tdata result, m_tlast
//   cfg_      cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// A rejected submit goes through S_RESP; an accepted submit goes through
// S_FIND, where the shared slot scanner tests the slots in turn up to the
// lowest free one. An interrupt event goes through S_DRAIN, where the scanner
// tests the slots up to the highest slot it reports. A quiet event leaves no word.
// Reset is synchronous, active low, and clears the pending and notify slot masks.
// A stalled output holds the scanner; the input is taken again once the last
// word of an item sits in the output register.
// ----------------------------------------------------------------------------
module command_slot_tracker
    import cst_pkg::*;
#(
    parameter int SLOT_COUNT = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input words.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   s_tuser,   // op
    input  logic [S_DATA_W-1:0]    s_tdata,   // running_mask, sector_count, notify,
                                              // int_status, zero fill
    // Result words.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic                   m_tuser,   // kind
    output logic [M_DATA_W-1:0]    m_tdata,   // status, slot, failed, zero fill
    output logic                   m_tlast,
    // Configuration writes.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_RESP,
        S_DRAIN
    } state_t;

    state_t                 state_reg;
    logic                   port_present_reg;
    logic [ENTRIES_W-1:0]   max_entries_reg;
    logic [CFG_DATA_W-1:0]  error_mask_reg;
    logic [SLOT_COUNT-1:0]  pending_reg;
    logic [SLOT_COUNT-1:0]  notify_reg;
    logic                   want_reg;
    logic                   failed_reg;
    status_t                resp_status_reg;

    logic                   m_valid_reg;
    logic                   m_kind_reg;
    status_t                m_status_reg;
    logic [SLOT_W-1:0]      m_slot_reg;
    logic                   m_failed_reg;
    logic                   m_last_reg;

    // Input word fields.
    logic                   in_op;
    logic [RUNNING_W-1:0]   in_running;
    logic [COUNT_W-1:0]     in_count;
    logic                   in_notify;
    logic [STATUS_IN_W-1:0] in_status;

    logic                   accept;
    logic                   out_free;
    logic                   out_load;
    logic [ENTRIES_W-1:0]   entries;
    logic [COUNT_W:0]       count_rounded;
    logic [SLOT_COUNT-1:0]  free_bits;
    logic [SLOT_COUNT-1:0]  done_bits;
    logic [SLOT_COUNT-1:0]  emit_bits;
    logic                   err_hit;
    status_t                sub_status;

    scan_ctrl_t             scan_ctrl;
    scan_stat_t             scan_stat;
    logic [SLOT_W-1:0]      scan_slot;
    logic [SLOT_COUNT-1:0]  scan_mask;

    assign in_op      = s_tuser;
    assign in_running = s_tdata[RUNNING_W-1:0];
    assign in_count   = s_tdata[RUNNING_W +: COUNT_W];
    assign in_notify  = s_tdata[RUNNING_W + COUNT_W];
    assign in_status  = s_tdata[RUNNING_W + COUNT_W + 1 +: STATUS_IN_W];

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // A new word goes into the output register in this cycle.
    assign out_load  = out_free && ((state_reg == S_RESP)
                     || (((state_reg == S_FIND) || (state_reg == S_DRAIN))
                      && scan_stat.hit));

    // Request checks and slot masks of the word being taken.
    always_comb begin
        count_rounded = {1'b0, in_count} + ENTRY_ROUND;
        entries       = count_rounded[COUNT_W:4];
        free_bits     = ~in_running[SLOT_COUNT-1:0];
        err_hit       = |(in_status & error_mask_reg);
        done_bits     = (pending_reg & ~in_running[SLOT_COUNT-1:0])
                      | (err_hit ? pending_reg : '0);
        emit_bits     = done_bits & notify_reg;

        priority if (in_count == '0) begin
            sub_status = STAT_ZERO_COUNT;
        end else if (!port_present_reg) begin
            sub_status = STAT_NO_PORT;
        end else if (entries > max_entries_reg) begin
            sub_status = STAT_TOO_MANY;
        end else if (free_bits == '0) begin
            sub_status = STAT_NO_SLOT;
        end else begin
            sub_status = STAT_ACCEPTED;
        end
    end

    // Scanner control: load on a new scan, step over clear slots or once a
    // reported slot has gone into the output register.
    always_comb begin
        scan_mask      = (in_op == OP_SUBMIT) ? free_bits : emit_bits;
        scan_ctrl.load = accept && (state_reg == S_IDLE)
                      && (((in_op == OP_SUBMIT) && (sub_status == STAT_ACCEPTED))
                       || ((in_op == OP_INTERRUPT) && (in_status != '0)
                        && (emit_bits != '0)));
        scan_ctrl.step = ((state_reg == S_FIND) && !scan_stat.hit)
                      || ((state_reg == S_DRAIN) && (!scan_stat.hit || out_free));
    end

    cst_scan #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_scan (
        .aclk      (aclk),
        .ctrl      (scan_ctrl),
        .load_mask (scan_mask),
        .stat      (scan_stat),
        .cursor    (scan_slot)
    );

    // Sequencer, slot state, configuration and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            m_valid_reg      <= 1'b0;
            port_present_reg <= 1'b0;
            max_entries_reg  <= MAX_ENTRIES_RESET;
            error_mask_reg   <= ERROR_MASK_RESET;
            pending_reg      <= '0;
            notify_reg       <= '0;
        end else begin
            // The output word leaves unless a new one is loaded in the same cycle.
            if (m_valid_reg && m_tready && !out_load) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_PORT_PRESENT: port_present_reg <= cfg_data[0];
                    CFG_MAX_ENTRIES:  max_entries_reg  <= cfg_data[ENTRIES_W-1:0];
                    CFG_ERROR_MASK:   error_mask_reg   <= cfg_data;
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if (in_op == OP_SUBMIT) begin
                            resp_status_reg <= sub_status;
                            want_reg        <= in_notify;
                            state_reg <= (sub_status == STAT_ACCEPTED) ? S_FIND : S_RESP;
                        end else if (in_status != '0) begin
                            pending_reg <= pending_reg & ~done_bits;
                            notify_reg  <= notify_reg & ~done_bits;
                            failed_reg  <= err_hit;
                            if (emit_bits != '0) begin
                                state_reg <= S_DRAIN;
                            end
                        end
                    end
                end
                S_FIND: begin
                    if (scan_stat.hit && out_free) begin
                        pending_reg[scan_slot] <= 1'b1;
                        notify_reg[scan_slot]  <= want_reg;
                        m_valid_reg  <= 1'b1;
                        m_kind_reg   <= KIND_SUBMIT;
                        m_status_reg <= STAT_ACCEPTED;
                        m_slot_reg   <= scan_slot;
                        m_failed_reg <= 1'b0;
                        m_last_reg   <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_kind_reg   <= KIND_SUBMIT;
                        m_status_reg <= resp_status_reg;
                        m_slot_reg   <= '0;
                        m_failed_reg <= 1'b0;
                        m_last_reg   <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                S_DRAIN: begin
                    if (scan_stat.hit && out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_kind_reg   <= KIND_COMPLETION;
                        m_status_reg <= STAT_ACCEPTED;
                        m_slot_reg   <= scan_slot;
                        m_failed_reg <= failed_reg;
                        m_last_reg   <= scan_stat.last;
                        if (scan_stat.last) begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
            endcase
        end
    end

    // Output word packing.
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(M_DATA_W - STATUS_W - SLOT_W - 1){1'b0}},
                       m_failed_reg, m_slot_reg, m_status_reg};

endmodule

[rtl/cst_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_scan: bit-serial slot scanner
// Holds a slot mask and a cursor, tests one slot per cycle when stepped, clears
// slots as they are consumed and tells whether the current slot is the last one set.
// ----------------------------------------------------------------------------
module cst_scan
    import cst_pkg::*;
#(
    parameter int SLOT_COUNT = 32
) (
    input  logic                  aclk,
    input  scan_ctrl_t            ctrl,
    input  logic [SLOT_COUNT-1:0] load_mask,
    output scan_stat_t            stat,
    output logic [SLOT_W-1:0]     cursor
);

    localparam int CW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [CW-1:0] CURSOR_MAX = CW'(SLOT_COUNT - 1);

    logic [SLOT_COUNT-1:0] work_reg;
    logic [CW-1:0]         cursor_reg;
    logic [SLOT_COUNT-1:0] work_next;

    // Current slot test and the mask with that slot taken out.
    always_comb begin
        work_next = work_reg & ~(SLOT_COUNT'(1) << cursor_reg);
        stat.hit  = work_reg[cursor_reg];
        stat.last = (work_next == '0);
    end

    assign cursor = SLOT_W'(cursor_reg);

    // Mask and cursor update: load starts a scan, step moves one slot on.
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            work_reg   <= load_mask;
            cursor_reg <= '0;
        end else if (ctrl.step) begin
            work_reg <= work_next;
            if (cursor_reg != CURSOR_MAX) begin
                cursor_reg <= cursor_reg + 1'b1;
            end
        end
    end

endmodule

[rtl/cst_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_checker: port-level checks of the command slot tracker
// Watches the result channel and checks the shape of the words it carries.
// ----------------------------------------------------------------------------
module cst_checker
    import cst_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic                m_tuser,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tlast
);

    // A stalled result word keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("result word changed while stalled");

    // A completion word always carries the accepted status.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_COMPLETION) |->
            (m_tdata[STATUS_W-1:0] == STAT_ACCEPTED))
        else $error("completion word with nonzero status");

    // A submit response is a single word with no failure flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_SUBMIT) |-> m_tlast && !m_tdata[STATUS_W + SLOT_W])
        else $error("submit response not a single clean word");

    // A rejected submit reports slot zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_SUBMIT) && (m_tdata[STATUS_W-1:0] != STAT_ACCEPTED)
            |-> (m_tdata[STATUS_W +: SLOT_W] == '0))
        else $error("rejected submit with a slot number");

endmodule

bind command_slot_tracker cst_checker u_cst_checker (.*);
